// ----- hw/rtl/wcs_pkg.sv -----
// Shared types, constants and duration table for the wash cycle sequencer.
package wcs_pkg;

    // Tick counter width
    localparam int COUNT_WIDTH = 9;

    // Stream payload widths (fields packed from bit 0, padded to bytes)
    localparam int IN_DATA_WIDTH  = 8;
    localparam int OUT_DATA_WIDTH = 16;

    typedef logic [COUNT_WIDTH-1:0] count_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_FILL  = 3'd1,
        PH_WASH  = 3'd2,
        PH_RINSE = 3'd3,
        PH_SPIN  = 3'd4,
        PH_FINAL = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        LVL_NONE = 2'd0,
        LVL_LOW  = 2'd1,
        LVL_MID  = 2'd2,
        LVL_HIGH = 2'd3
    } level_t;

    // One input transaction
    typedef struct packed {
        logic tick;
        logic start_press;
        logic low_press;
        logic mid_press;
        logic high_press;
    } item_t;

    // Sequencer state carried between transactions
    typedef struct packed {
        phase_t     phase;
        level_t     level;
        count_t     tick_count;
        logic       start_latched;
        logic [2:0] level_latches; // bit 0 low, bit 1 medium, bit 2 high
    } seq_state_t;

    // One result transaction
    typedef struct packed {
        phase_t phase;
        level_t level;
        logic   fill_on;
        logic   wash_on;
        logic   rinse_on;
        logic   spin_on;
        logic   started;
        logic   done_res;
    } result_t;

    // Phase durations in ticks, indexed [level][phase - fill]
    localparam count_t DUR_TABLE [4][4] = '{
        '{count_t'(0),   count_t'(0),   count_t'(0),   count_t'(0)},
        '{count_t'(30),  count_t'(150), count_t'(90),  count_t'(150)},
        '{count_t'(90),  count_t'(390), count_t'(210), count_t'(240)},
        '{count_t'(150), count_t'(480), count_t'(270), count_t'(480)}
    };

endpackage

// ----- hw/rtl/wcs_step.sv -----
// Next-state and result logic for one sequencer transaction.
module wcs_step
    import wcs_pkg::*;
(
    input  seq_state_t state_cur,
    input  item_t      item,
    output seq_state_t state_nxt,
    output result_t    result
);

    logic       start_upd;
    logic [2:0] latches_upd;
    logic [1:0] phase_idx;
    count_t     limit;
    logic       done;

    // Latch updates and table lookup
    always_comb begin
        start_upd   = state_cur.start_latched | item.start_press;
        latches_upd = state_cur.level_latches
                    | {item.high_press, item.mid_press, item.low_press};
        phase_idx   = 2'(state_cur.phase - PH_FILL);
        limit       = DUR_TABLE[state_cur.level][phase_idx];
    end

    // Phase sequencing
    always_comb begin
        state_nxt = state_cur;
        done      = 1'b0;
        case (state_cur.phase)
            PH_IDLE: begin
                state_nxt.start_latched = start_upd;
                state_nxt.level_latches = latches_upd;
                state_nxt.tick_count    = '0;
                if (start_upd && (latches_upd != 3'b000)) begin
                    // low wins over medium, medium over high
                    if (latches_upd[0]) begin
                        state_nxt.level = LVL_LOW;
                    end else if (latches_upd[1]) begin
                        state_nxt.level = LVL_MID;
                    end else begin
                        state_nxt.level = LVL_HIGH;
                    end
                    state_nxt.phase = PH_FILL;
                end
            end
            PH_FILL, PH_WASH, PH_RINSE, PH_SPIN: begin
                if (item.tick) begin
                    if (state_cur.tick_count == limit) begin
                        state_nxt.tick_count = '0;
                        state_nxt.phase      = phase_t'(state_cur.phase + 3'd1);
                    end else begin
                        state_nxt.tick_count = state_cur.tick_count + count_t'(1);
                    end
                end
            end
            default: begin
                // final step and unused codes: back to idle, clear latches
                state_nxt.phase         = PH_IDLE;
                state_nxt.level         = LVL_NONE;
                state_nxt.tick_count    = '0;
                state_nxt.start_latched = 1'b0;
                state_nxt.level_latches = 3'b000;
                done                    = 1'b1;
            end
        endcase
    end

    // Result reflects the state after this transaction
    always_comb begin
        result.phase    = state_nxt.phase;
        result.level    = state_nxt.level;
        result.fill_on  = (state_nxt.phase == PH_FILL);
        result.wash_on  = (state_nxt.phase == PH_WASH);
        result.rinse_on = (state_nxt.phase == PH_RINSE);
        result.spin_on  = (state_nxt.phase == PH_SPIN);
        result.started  = state_nxt.start_latched;
        result.done_res = done;
    end

endmodule

// ----- hw/rtl/wash_cycle_sequencer.sv -----
// Top level of the wash cycle sequencer: input register, state, result register.
//
//  channel | dir | payload (tdata, from bit 0)
//  s_      | in  | tick, start_press, low_press, mid_press, high_press, pad to 8
//  m_      | out | phase[3], level[2], fill_on, wash_on, rinse_on, spin_on,
//          |     | started, done_res, pad to 16
//
// One transaction per cycle sustained while the output is not stalled; an accepted
// input passes through the input register, then the result register.
// The state update is a single table lookup and 9-bit compare per cycle.
// aresetn is synchronous, active low; it clears valids and sequencer state.
// A stalled output holds its result; the input register keeps taking a new
// transaction whenever its content moves on in the same cycle.
module wash_cycle_sequencer
    import wcs_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    // tick, start_press, low_press, mid_press, high_press
    input  logic [IN_DATA_WIDTH-1:0]  s_tdata,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // phase[2:0], level[4:3], fill_on, wash_on, rinse_on, spin_on, started, done_res
    output logic [OUT_DATA_WIDTH-1:0] m_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready
);

    item_t      in_item_reg;
    logic       in_valid_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    out_res_reg;
    result_t    result_next;
    logic       out_valid_reg;
    logic       advance;

    // Move the held transaction into the result register when it has room
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    wcs_step u_step (
        .state_cur (state_reg),
        .item      (in_item_reg),
        .state_nxt (state_next),
        .result    (result_next)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_item_reg.tick        <= s_tdata[0];
            in_item_reg.start_press <= s_tdata[1];
            in_item_reg.low_press   <= s_tdata[2];
            in_item_reg.mid_press   <= s_tdata[3];
            in_item_reg.high_press  <= s_tdata[4];
        end
    end

    // Sequencer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase         <= PH_IDLE;
            state_reg.level         <= LVL_NONE;
            state_reg.tick_count    <= '0;
            state_reg.start_latched <= 1'b0;
            state_reg.level_latches <= 3'b000;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_res_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000,
                       out_res_reg.done_res,
                       out_res_reg.started,
                       out_res_reg.spin_on,
                       out_res_reg.rinse_on,
                       out_res_reg.wash_on,
                       out_res_reg.fill_on,
                       out_res_reg.level,
                       out_res_reg.phase};

endmodule

// ----- hw/rtl/wcs_checker.sv -----
// Port-level checker for the wash cycle sequencer, bound to the top level.
module wcs_checker
    import wcs_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic [OUT_DATA_WIDTH-1:0] m_tdata,
    input logic                      m_tvalid,
    input logic                      m_tready
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Drive outputs follow the phase field exactly
    a_drive_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[5] == (m_tdata[2:0] == PH_FILL))
                  && (m_tdata[6] == (m_tdata[2:0] == PH_WASH))
                  && (m_tdata[7] == (m_tdata[2:0] == PH_RINSE))
                  && (m_tdata[8] == (m_tdata[2:0] == PH_SPIN)))
        else $error("drive outputs disagree with phase");

    // A running or final phase always has a level and a latched start
    a_run_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:0] != PH_IDLE)
            |-> (m_tdata[4:3] != LVL_NONE) && m_tdata[9])
        else $error("running without level or start");

    // Cycle completion returns to a cleared idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10]
            |-> (m_tdata[2:0] == PH_IDLE) && (m_tdata[4:3] == LVL_NONE) && !m_tdata[9])
        else $error("done without return to cleared idle");

    // Reset clears the result valid
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind wash_cycle_sequencer wcs_checker u_wcs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);
